/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the packer modules.
// Every module that uses them has clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside of reset.
`define MBP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("packer assertion failed");

// Condition that must never be seen outside of reset.
`define MBP_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("packer forbidden condition seen");

`endif

/* hw/rtl/mbp_pkg.sv */
package mbp_pkg;

  localparam int WordBits     = 64;
  localparam int MaxFieldBits = 57;
  localparam int ByteBits     = 8;
  localparam int HeldW        = $clog2(WordBits + 1);
  localparam int CountW       = 6;
  localparam int ByteIdxW     = $clog2(WordBits / ByteBits);
  localparam int FifoDepth    = 4;
  localparam int FifoPtrW     = $clog2(FifoDepth);
  localparam int FifoCntW     = $clog2(FifoDepth + 1);

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_FLUSH  = 1'b1
  } opcode_e;

  // A run of whole bytes to send: the bytes sit from bit 63 downward and
  // last_idx is the index of the final byte of the run.
  typedef struct packed {
    logic [WordBits-1:0] data;
    logic [ByteIdxW-1:0] last_idx;
  } job_t;

endpackage

/* hw/rtl/mbp_front.sv */
`include "assert_macros.svh"

module mbp_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic                         opcode_i,
  input  logic [mbp_pkg::WordBits-1:0] source_word_i,
  input  logic [mbp_pkg::CountW-1:0]   start_offset_i,
  input  logic [mbp_pkg::CountW-1:0]   bit_count_i,
  output logic                         job_valid_o,
  output mbp_pkg::job_t                job_o,
  input  logic                         job_full_i
);
  import mbp_pkg::*;

  // Extraction stage.
  logic                a_valid_q;
  opcode_e             a_op_q;
  logic [CountW-1:0]   a_cnt_q;
  logic [WordBits-1:0] a_field_q;

  logic [HeldW-1:0]    lim;
  logic [HeldW-1:0]    cnt_clamp;
  logic [WordBits-1:0] field;
  logic                a_accept;

  // Accumulator stage.
  logic [WordBits-1:0] acc_q, acc_d, acc_base;
  logic [HeldW-1:0]    held_q, held_d, held_base;
  logic [HeldW-1:0]    sum;
  logic [HeldW-1:0]    held_round;
  logic [3:0]          whole;
  logic [3:0]          flush_bytes;
  logic [3:0]          run_bytes;
  logic                is_flush;
  logic                drain;
  logic                b_go;

  // The count is limited so the field never runs past the word's LSB and
  // always fits after a drain. The field is left-aligned for appending.
  always_comb begin
    lim       = HeldW'(WordBits) - HeldW'(start_offset_i);
    cnt_clamp = HeldW'(bit_count_i);
    if (cnt_clamp > lim) begin
      cnt_clamp = lim;
    end
    if (cnt_clamp > HeldW'(MaxFieldBits)) begin
      cnt_clamp = HeldW'(MaxFieldBits);
    end
    field = (source_word_i << start_offset_i) & ~({WordBits{1'b1}} >> cnt_clamp);
  end

  assign a_accept = push && !full;

  always_comb begin
    is_flush    = (a_op_q == OP_FLUSH);
    sum         = held_q + HeldW'(a_cnt_q);
    drain       = !is_flush && (sum > HeldW'(WordBits));
    whole       = held_q[HeldW-1:3];
    held_round  = held_q + HeldW'(ByteBits - 1);
    flush_bytes = held_round[HeldW-1:3];
    run_bytes   = is_flush ? flush_bytes : whole;

    job_valid_o   = a_valid_q && (is_flush ? (flush_bytes != 4'd0) : drain);
    job_o.data    = acc_q;
    job_o.last_idx = ByteIdxW'(run_bytes - 4'd1);

    b_go = a_valid_q && !(job_valid_o && job_full_i);

    // Drained bytes leave the top; the 0..7 leftover bits move up.
    if (drain) begin
      acc_base  = whole[3] ? '0 : (acc_q << {whole[2:0], 3'b000});
      held_base = {4'b0000, held_q[2:0]};
    end else begin
      acc_base  = acc_q;
      held_base = held_q;
    end

    if (is_flush) begin
      acc_d  = '0;
      held_d = '0;
    end else begin
      acc_d  = acc_base | (a_field_q >> held_base);
      held_d = held_base + HeldW'(a_cnt_q);
    end
  end

  assign full = a_valid_q && !b_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      acc_q     <= '0;
      held_q    <= '0;
    end else begin
      if (a_accept) begin
        a_valid_q <= 1'b1;
      end else if (b_go) begin
        a_valid_q <= 1'b0;
      end
      if (b_go) begin
        acc_q  <= acc_d;
        held_q <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_accept) begin
      a_op_q    <= opcode_e'(opcode_i);
      a_cnt_q   <= cnt_clamp[CountW-1:0];
      a_field_q <= field;
    end
  end

  `MBP_ASSERT(held_in_range_a, held_q <= HeldW'(WordBits))
  `MBP_ASSERT(flush_clears_a, (b_go && a_op_q == OP_FLUSH) |=> (held_q == '0))
  `MBP_ASSERT(stall_holds_item_a, (a_valid_q && !b_go) |=> a_valid_q)

endmodule

/* hw/rtl/mbp_job_fifo.sv */
`include "assert_macros.svh"

module mbp_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mbp_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output mbp_pkg::job_t data_o
);
  import mbp_pkg::*;

  job_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // The writer may hold its request while the queue is full; the reader
  // only asks when something is stored.
  `MBP_ASSERT(fifo_count_a, cnt_q <= FifoCntW'(FifoDepth))
  `MBP_NEVER(fifo_underrun_a, pop_i && empty_o)

endmodule

/* hw/rtl/mbp_serializer.sv */
`include "assert_macros.svh"

module mbp_serializer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mbp_pkg::job_t                job_i,
  input  logic                         job_empty_i,
  output logic                         job_pop_o,
  output logic                         empty,
  input  logic                         pop,
  output logic [mbp_pkg::ByteBits-1:0] out_byte_o,
  output logic                         last_of_run_o
);
  import mbp_pkg::*;

  logic                valid_q;
  logic [WordBits-1:0] data_q;
  logic [ByteIdxW-1:0] idx_q, last_q;
  logic                pop_fire, at_last, load;

  assign pop_fire      = pop && valid_q;
  assign at_last       = (idx_q == last_q);
  assign load          = !valid_q || (pop_fire && at_last);
  assign job_pop_o     = load && !job_empty_i;
  assign empty         = !valid_q;
  assign out_byte_o    = data_q[WordBits-1 -: ByteBits];
  assign last_of_run_o = at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
      last_q  <= '0;
    end else if (load) begin
      valid_q <= !job_empty_i;
      idx_q   <= '0;
      last_q  <= job_i.last_idx;
    end else if (pop_fire) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= job_i.data;
    end else if (pop_fire) begin
      data_q <= data_q << ByteBits;
    end
  end

  `MBP_ASSERT(idx_in_run_a, valid_q |-> (idx_q <= last_q))
  `MBP_ASSERT(run_continues_a, (pop_fire && !at_last) |=> valid_q)

endmodule

/* hw/rtl/msb_first_bit_packer_core.sv */
// MSB-first bit packer. Bit fields are appended to a 64-bit accumulator,
// earliest bit on top, and whole bytes leave most significant byte first.
// Input channel: an item transfers on a rising edge with push high and full
// low. opcode_i 0 appends bit_count_i bits, clamped to 57 and to the word's
// LSB, of source_word_i from start_offset_i bits below its MSB; opcode_i 1
// flushes the held bits, last byte zero-padded, and clears the accumulator.
// Result channel: while empty is low, out_byte_o and last_of_run_o show the
// oldest byte; it transfers on a rising edge with pop high. last_of_run_o
// marks the final byte released by one input item.
// Path: an item's first released byte passes the extraction register, the
// run queue and the output register before it shows on the result ports.
// Items that release no byte never stall, so such items stream at one per
// cycle. Released bytes go out one per cycle from the output register while
// pop is high, up to eight per item; that byte stage sets the sustained rate.
// A four-entry run queue sits between the accumulator and the output
// register, so a stalled receiver only backs up into full once it is filled.
// Reset empties the accumulator, the queue and the output register.

module msb_first_bit_packer_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic                         opcode_i,
  input  logic [mbp_pkg::WordBits-1:0] source_word_i,
  input  logic [mbp_pkg::CountW-1:0]   start_offset_i,
  input  logic [mbp_pkg::CountW-1:0]   bit_count_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [mbp_pkg::ByteBits-1:0] out_byte_o,
  output logic                         last_of_run_o
);
  import mbp_pkg::*;

  // Runs of whole bytes handed from the accumulator to the byte stage.
  logic job_push, job_full, job_empty, job_pop;
  job_t job_in, job_out;

  // Front: clamps the count, extracts the field and updates the accumulator;
  // every drain and every flush with bits held becomes one run in the queue.
  mbp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .opcode_i       (opcode_i),
    .source_word_i  (source_word_i),
    .start_offset_i (start_offset_i),
    .bit_count_i    (bit_count_i),
    .job_valid_o    (job_push),
    .job_o          (job_in),
    .job_full_i     (job_full)
  );

  mbp_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .data_o  (job_out)
  );

  // Back: sends each run one byte per transfer, moving straight on to the
  // next run when the last byte of one leaves.
  mbp_serializer u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (job_out),
    .job_empty_i   (job_empty),
    .job_pop_o     (job_pop),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
